// ----- hw/rtl/qmi_pkg.sv -----
// ----------------------------------------------------------------------------
// qmi_pkg
// Shared types and codes for the queue with middle insertion.
// ----------------------------------------------------------------------------
`default_nettype none

package qmi_pkg;

   localparam int DEF_CAPACITY   = 1024;
   localparam int DEF_VALUE_BITS = 32;

   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_DEQUEUE = 2'd1;
   localparam logic [1:0] OP_INSERT  = 2'd2;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [31:0] item_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               value_valid;
      logic signed [31:0] popped_value;
   } rsp_type;

endpackage

`default_nettype wire

// ----- hw/rtl/qmi_ram.sv -----
// ----------------------------------------------------------------------------
// qmi_ram
// One half store: single write port, single registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module qmi_ram #(
   parameter int DEPTH      = 512,
   parameter int ADDR_BITS  = 9,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_BITS-1:0]  wr_addr,
   input  wire logic [VALUE_BITS-1:0] wr_data,
   input  wire logic                  rd_en,
   input  wire logic [ADDR_BITS-1:0]  rd_addr,
   output logic      [VALUE_BITS-1:0] rd_data
);

   logic [VALUE_BITS-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/queue_with_middle_insert.sv -----
// ----------------------------------------------------------------------------
// queue_with_middle_insert
// Bounded FIFO with enqueue, dequeue and insertion at the middle.
// ----------------------------------------------------------------------------
// Each item passes through S_IDLE and S_MOVE: the accept cycle updates the
// pointers, writes a pushed value and issues the read for the one-item
// rebalance move; the next cycle (S_MOVE) writes the registered read data into
// the other half. No new item is taken until the move is done. A new item is
// taken while an earlier result still waits on the result port; a result that
// cannot leave is parked in a skid register (S_HOLD) and stalls new requests.
// No clearing pass is needed after reset: only occupied entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module queue_with_middle_insert #(
   parameter int CAPACITY   = qmi_pkg::DEF_CAPACITY,
   parameter int VALUE_BITS = qmi_pkg::DEF_VALUE_BITS
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire qmi_pkg::req_type req_item,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output qmi_pkg::rsp_type     rsp_item
);

   localparam int HALF_DEPTH = (CAPACITY + 1) / 2;
   localparam int AW = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
   localparam int CW = $clog2(HALF_DEPTH + 1);
   localparam int TW = CW + 1;
   localparam logic [AW-1:0] LAST  = AW'(HALF_DEPTH - 1);
   localparam logic [TW-1:0] CAP_T = TW'(CAPACITY);
   localparam logic [CW:0]   HD_S  = (CW + 1)'(HALF_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_MOVE = 3'b010,
      S_HOLD = 3'b100
   } state_type;

   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      ptr_inc = (p == LAST) ? '0 : AW'(p + 1'b1);
   endfunction

   function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
      ptr_dec = (p == '0) ? LAST : AW'(p - 1'b1);
   endfunction

   function automatic logic [AW-1:0] slot(input logic [AW-1:0] s, input logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = (CW + 1)'(s) + (CW + 1)'(off);
      if (sum >= HD_S) begin
         sum = sum - HD_S;
      end
      slot = AW'(sum);
   endfunction

   state_type state_ff, state_in;
   logic [AW-1:0] hs_ff, hs_in, ts_ff, ts_in;
   logic [CW-1:0] hc_ff, hc_in, tc_ff, tc_in;
   logic rsp_valid_ff, rsp_valid_in;
   qmi_pkg::rsp_type rsp_ff, rsp_in, pend_ff, pend_in;
   logic [1:0] status_ff, status_in;
   logic pop_ff, pop_in, t2h_ff, t2h_in, h2t_ff, h2t_in, fwd_ff, fwd_in;
   logic [AW-1:0] mv_addr_ff, mv_addr_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;

   logic                  h_wr_en, h_rd_en, t_wr_en, t_rd_en;
   logic [AW-1:0]         h_wr_addr, h_rd_addr, t_wr_addr, t_rd_addr;
   logic [VALUE_BITS-1:0] h_wr_data, t_wr_data, h_rd_data, t_rd_data;

   logic accept, out_free;
   logic is_push, is_pop, do_push, do_pop, full, mv_t2h, mv_h2t;
   logic [TW-1:0] total, total1, want;
   logic [AW-1:0] hs1, ts1, push_addr;
   logic [CW-1:0] hc1, tc1;
   logic [63:0] in_wide, out_wide;
   logic [VALUE_BITS-1:0] in_val;
   qmi_pkg::rsp_type result;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assign in_wide  = 64'($unsigned(req_item.item_value));
   assign in_val   = in_wide[VALUE_BITS-1:0];
   assign out_wide = 64'(h_rd_data);

   always_comb begin
      is_push = (req_item.opcode == qmi_pkg::OP_ENQUEUE) ||
                (req_item.opcode == qmi_pkg::OP_INSERT);
      is_pop  = (req_item.opcode == qmi_pkg::OP_DEQUEUE);
      total   = TW'(hc_ff) + TW'(tc_ff);
      full    = (total >= CAP_T);
      do_push = is_push && !full;
      do_pop  = is_pop && (hc_ff != '0);

      hs1 = do_pop ? ptr_inc(hs_ff) : hs_ff;
      hc1 = do_pop ? CW'(hc_ff - 1'b1) : hc_ff;
      push_addr = (req_item.opcode == qmi_pkg::OP_INSERT) ? ptr_dec(ts_ff) : slot(ts_ff, tc_ff);
      ts1 = (do_push && (req_item.opcode == qmi_pkg::OP_INSERT)) ? push_addr : ts_ff;
      tc1 = do_push ? CW'(tc_ff + 1'b1) : tc_ff;

      total1 = TW'(hc1) + TW'(tc1);
      want   = TW'((total1 + TW'(1)) >> 1);
      mv_t2h = (do_push || do_pop) && (TW'(hc1) < want) && (tc1 != '0);
      mv_h2t = (do_push || do_pop) && !mv_t2h && (TW'(hc1) > want) && (hc1 != '0);

      state_in     = state_ff;
      hs_in        = hs_ff;
      hc_in        = hc_ff;
      ts_in        = ts_ff;
      tc_in        = tc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      pend_in      = pend_ff;
      status_in    = status_ff;
      pop_in       = pop_ff;
      t2h_in       = t2h_ff;
      h2t_in       = h2t_ff;
      fwd_in       = fwd_ff;
      mv_addr_in   = mv_addr_ff;
      val_in       = val_ff;

      h_rd_en   = 1'b0;
      h_rd_addr = do_pop ? hs_ff : slot(hs1, CW'(hc1 - 1'b1));
      t_rd_en   = 1'b0;
      t_rd_addr = ts1;
      h_wr_en   = 1'b0;
      h_wr_addr = mv_addr_ff;
      h_wr_data = fwd_ff ? val_ff : t_rd_data;
      t_wr_en   = 1'b0;
      t_wr_addr = push_addr;
      t_wr_data = in_val;

      result.status       = status_ff;
      result.value_valid  = pop_ff;
      result.popped_value = pop_ff ? out_wide[31:0] : '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               h_rd_en = do_pop || mv_h2t;
               t_rd_en = mv_t2h;
               t_wr_en = do_push;
               status_in = (is_push && full) ? qmi_pkg::ST_FULL :
                           (is_pop && !do_pop) ? qmi_pkg::ST_EMPTY : qmi_pkg::ST_DONE;
               pop_in = do_pop;
               t2h_in = mv_t2h;
               h2t_in = mv_h2t;
               fwd_in = do_push && (push_addr == ts1);
               val_in = in_val;
               hs_in  = hs1;
               if (mv_t2h) begin
                  mv_addr_in = slot(hs1, hc1);
                  ts_in = ptr_inc(ts1);
                  tc_in = CW'(tc1 - 1'b1);
                  hc_in = CW'(hc1 + 1'b1);
               end else if (mv_h2t) begin
                  mv_addr_in = ptr_dec(ts1);
                  ts_in = ptr_dec(ts1);
                  tc_in = CW'(tc1 + 1'b1);
                  hc_in = CW'(hc1 - 1'b1);
               end else begin
                  ts_in = ts1;
                  tc_in = tc1;
                  hc_in = hc1;
               end
               state_in = S_MOVE;
            end
         end
         S_MOVE: begin
            h_wr_en   = t2h_ff;
            t_wr_en   = h2t_ff;
            t_wr_addr = mv_addr_ff;
            t_wr_data = h_rd_data;
            if (out_free) begin
               rsp_in       = result;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               pend_in  = result;
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (out_free) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hs_ff        <= '0;
         hc_ff        <= '0;
         ts_ff        <= '0;
         tc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hs_ff        <= hs_in;
         hc_ff        <= hc_in;
         ts_ff        <= ts_in;
         tc_ff        <= tc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff     <= rsp_in;
      pend_ff    <= pend_in;
      status_ff  <= status_in;
      pop_ff     <= pop_in;
      t2h_ff     <= t2h_in;
      h2t_ff     <= h2t_in;
      fwd_ff     <= fwd_in;
      mv_addr_ff <= mv_addr_in;
      val_ff     <= val_in;
   end

   qmi_ram #(
      .DEPTH      (HALF_DEPTH),
      .ADDR_BITS  (AW),
      .VALUE_BITS (VALUE_BITS)
   ) u_head_ram (
      .clock   (clock),
      .wr_en   (h_wr_en),
      .wr_addr (h_wr_addr),
      .wr_data (h_wr_data),
      .rd_en   (h_rd_en),
      .rd_addr (h_rd_addr),
      .rd_data (h_rd_data)
   );

   qmi_ram #(
      .DEPTH      (HALF_DEPTH),
      .ADDR_BITS  (AW),
      .VALUE_BITS (VALUE_BITS)
   ) u_tail_ram (
      .clock   (clock),
      .wr_en   (t_wr_en),
      .wr_addr (t_wr_addr),
      .wr_data (t_wr_data),
      .rd_en   (t_rd_en),
      .rd_addr (t_rd_addr),
      .rd_data (t_rd_data)
   );

endmodule

`default_nettype wire

// ----- tb/queue_with_middle_insert_tb.sv -----
// ----------------------------------------------------------------------------
// queue_with_middle_insert_tb
// Self-checking bench for the queue with middle insertion.
// ----------------------------------------------------------------------------
// A clocked driver presents enqueue, dequeue, middle-insert and reserved
// operations from a list built up front: a directed opening, random traffic
// in four phases of varied idling and result stalls, then a drain to empty. A
// clocked monitor predicts each accepted item with a queue image of its own
// and checks every result field against the oldest prediction, in order.
// ----------------------------------------------------------------------------

module queue_with_middle_insert_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import qmi_pkg::*;

   localparam int         QUEUE_CAPACITY = DEF_CAPACITY;
   localparam logic [1:0] OP_RESERVED    = 2'd3;

   typedef struct {
      req_type     req;
      int unsigned idle_pct;
      int unsigned stall_pct;
      bit          settle;
   } pending_item_t;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   pending_item_t      pending_items[$];
   rsp_type            awaited_results[$];
   logic signed [31:0] queue_image[$];
   rsp_type            awaited;
   int unsigned        recv_stall_pct = 0;
   int unsigned        gen_depth      = 0;
   int unsigned        mismatch_count = 0;
   int unsigned        idle_by_phase [4] = '{0, 60, 0, 21};
   int unsigned        stall_by_phase[4] = '{0, 0, 60, 21};

   queue_with_middle_insert i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic rsp_type apply_queue_op(req_type req);
      rsp_type     rsp;
      int unsigned depth;
      rsp = '0;
      rsp.status = ST_DONE;
      depth = queue_image.size();
      case (req.opcode)
         OP_ENQUEUE, OP_INSERT: begin
            if (depth >= QUEUE_CAPACITY) begin
               rsp.status = ST_FULL;
            end else if (req.opcode == OP_ENQUEUE) begin
               queue_image.push_back(req.item_value);
            end else begin
               queue_image.insert((depth + 1) / 2, req.item_value);
            end
         end
         OP_DEQUEUE: begin
            if (depth == 0) begin
               rsp.status = ST_EMPTY;
            end else begin
               rsp.value_valid  = 1'b1;
               rsp.popped_value = queue_image.pop_front();
            end
         end
         default: begin
         end
      endcase
      return rsp;
   endfunction

   task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
      end
   endtask

   task automatic queue_request(logic [1:0] op, logic [31:0] value, int unsigned idle_pct,
                                int unsigned stall_pct, bit settle = 1'b0);
      pending_item_t entry;
      entry.req.opcode     = op;
      entry.req.item_value = value;
      entry.idle_pct       = idle_pct;
      entry.stall_pct      = stall_pct;
      entry.settle         = settle;
      pending_items.push_back(entry);
      if ((op == OP_ENQUEUE || op == OP_INSERT) && gen_depth < QUEUE_CAPACITY) begin
         gen_depth++;
      end else if (op == OP_DEQUEUE && gen_depth > 0) begin
         gen_depth--;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && req_stall) begin
      end else if (pending_items.size() != 0
                   && $urandom_range(99) >= pending_items[0].idle_pct
                   && !(pending_items[0].settle
                        && (req_valid || awaited_results.size() != 0))) begin
         req_valid      <= 1'b1;
         req_item       <= pending_items[0].req;
         recv_stall_pct <= pending_items[0].stall_pct;
         pending_items.delete(0);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            awaited_results.push_back(apply_queue_op(req_item));
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               flag_mismatch("unrequested item", '0, rsp_item.popped_value);
            end else begin
               awaited = awaited_results.pop_front();
               if (rsp_item.status !== awaited.status) begin
                  flag_mismatch("status", 32'(awaited.status), 32'(rsp_item.status));
               end
               if (rsp_item.value_valid !== awaited.value_valid) begin
                  flag_mismatch("value_valid", 32'(awaited.value_valid),
                                32'(rsp_item.value_valid));
               end
               if (rsp_item.popped_value !== awaited.popped_value) begin
                  flag_mismatch("popped_value", awaited.popped_value, rsp_item.popped_value);
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   initial begin
      int unsigned pick;
      int unsigned push_limit;
      logic [1:0]  op;

      queue_request(OP_DEQUEUE,  32'h1234_5678, 0, 0);
      queue_request(OP_RESERVED, 32'hFFFF_FFFF, 0, 0);
      queue_request(OP_INSERT,   32'h0000_0001, 0, 0);
      queue_request(OP_DEQUEUE,  32'h0000_0000, 0, 0);
      queue_request(OP_ENQUEUE,  32'h7FFF_FFFF, 0, 0);
      queue_request(OP_ENQUEUE,  32'h8000_0000, 0, 0);
      queue_request(OP_INSERT,   32'hFFFF_FFFF, 0, 0);
      queue_request(OP_INSERT,   32'h0000_0000, 0, 0);
      queue_request(OP_ENQUEUE,  32'hAAAA_AAAA, 0, 0);
      queue_request(OP_INSERT,   32'h5555_5555, 0, 0);
      queue_request(OP_RESERVED, 32'h0000_0000, 0, 0);
      queue_request(OP_INSERT,   32'h0000_0001, 0, 0);
      repeat (8) queue_request(OP_DEQUEUE, $urandom(), 0, 0);
      queue_request(OP_ENQUEUE,  32'hFFFF_FFFE, 0, 0);
      queue_request(OP_DEQUEUE,  32'h0000_0000, 0, 0);

      for (int phase = 0; phase < 4; phase++) begin
         for (int n = 0; n < 100; n++) begin
            pick = $urandom_range(99);
            push_limit = (gen_depth < 4) ? 80 : ((gen_depth > 40) ? 40 : 56);
            if (pick < 3) begin
               op = OP_RESERVED;
            end else if (pick < push_limit) begin
               op = $urandom_range(1) ? OP_INSERT : OP_ENQUEUE;
            end else begin
               op = OP_DEQUEUE;
            end
            queue_request(op, $urandom(), idle_by_phase[phase], stall_by_phase[phase],
                          phase == 2 && n == 0);
         end
      end

      while (gen_depth > 0) begin
         queue_request(OP_DEQUEUE, $urandom(), 0, 60);
      end
      queue_request(OP_DEQUEUE, $urandom(), 0, 60);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_valid || awaited_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      if (awaited_results.size() != 0) begin
         $display("%0d expected items never arrived", awaited_results.size());
         mismatch_count += awaited_results.size();
      end
      if (mismatch_count == 0) begin
         $display("queue_with_middle_insert_tb: PASS");
      end else begin
         $display("queue_with_middle_insert_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("timeout waiting for results");
      $display("queue_with_middle_insert_tb: FAIL");
      $finish;
   end

endmodule
